>>> rtl/core/rtpnal_pkg.sv
// shared types and constants for the rtp nal depacketizer
package rtpnal_pkg;

    localparam logic [1:0] MODE_DROP = 2'd0;
    localparam logic [1:0] MODE_PASS = 2'd1;
    localparam logic [1:0] MODE_FRAG = 2'd2;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_ABANDON = 2'd2;

    localparam logic [8:0] POS_MAX          = 9'd511;
    localparam logic [7:0] HEADER_LEN_RESET = 8'd12;

    localparam logic [4:0] H264_FU_TYPE    = 5'd28;
    localparam logic [5:0] H265_FU_TYPE    = 6'd49;
    localparam logic [7:0] H264_HDR_MASK   = 8'hE0;
    localparam logic [7:0] H265_HDR_MASK   = 8'h81;
    localparam logic [7:0] H265_SECOND_HDR = 8'h01;
    localparam logic [7:0] START_CODE_ZERO = 8'h00;
    localparam logic [7:0] START_CODE_LAST = 8'h01;
    localparam logic [8:0] H264_FU_POS     = 9'd1;
    localparam logic [8:0] H265_FU_POS     = 9'd2;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int NSLOTS       = 8;
    localparam int SLOT_ABANDON = 0;
    localparam int SLOT_SC0     = 1;
    localparam int SLOT_SC1     = 2;
    localparam int SLOT_SC2     = 3;
    localparam int SLOT_SC3     = 4;
    localparam int SLOT_BYTE0   = 5;
    localparam int SLOT_BYTE1   = 6;
    localparam int SLOT_END     = 7;

    typedef struct packed {
        logic        abandon;
        logic        start;
        logic [1:0]  nbytes;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic        close;
        logic [31:0] total;
    } rtpnal_cmd_t;

endpackage

>>> rtl/core/rtpnal_front.sv
// front end: tracks packet position and fragment state, emits at most one command per byte
module rtpnal_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_data_byte,
    input  logic                    s_first_in_packet,
    input  logic                    s_last_in_packet,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [7:0]              cfg_data,
    input  logic                    q_full,
    output logic                    q_wr,
    output rtpnal_pkg::rtpnal_cmd_t q_data
);

    logic [7:0]  header_len_reg;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  held_reg, held_next;
    logic [1:0]  mode_reg, mode_next;
    logic        hevc_reg, hevc_next;
    logic        end_seen_reg, end_seen_next;
    logic        open_reg, open_next;
    logic [31:0] count_reg, count_next;
    rtpnal_pkg::rtpnal_cmd_t cmd;
    logic        accept;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    always_comb begin
        logic [8:0] p;
        logic [8:0] q;
        logic [8:0] fu_pos;
        p             = s_first_in_packet ? 9'd0 : pos_reg;
        q             = p - {1'b0, header_len_reg};
        mode_next     = mode_reg;
        hevc_next     = hevc_reg;
        end_seen_next = end_seen_reg;
        open_next     = open_reg;
        held_next     = held_reg;
        cmd           = '0;

        if (p == 9'd0) begin
            if (mode_next == rtpnal_pkg::MODE_PASS && open_next) begin
                cmd.abandon = 1'b1;
                open_next   = 1'b0;
            end
            mode_next     = rtpnal_pkg::MODE_DROP;
            hevc_next     = 1'b0;
            end_seen_next = 1'b0;
        end

        fu_pos = hevc_next ? rtpnal_pkg::H265_FU_POS : rtpnal_pkg::H264_FU_POS;

        if (p >= {1'b0, header_len_reg}) begin
            if (q == 9'd0) begin
                if (s_data_byte[4:0] == rtpnal_pkg::H264_FU_TYPE) begin
                    mode_next = rtpnal_pkg::MODE_FRAG;
                    hevc_next = 1'b0;
                    held_next = s_data_byte;
                end else if (s_data_byte[6:1] == rtpnal_pkg::H265_FU_TYPE) begin
                    mode_next = rtpnal_pkg::MODE_FRAG;
                    hevc_next = 1'b1;
                    held_next = s_data_byte;
                end else begin
                    if (open_next) begin
                        cmd.abandon = 1'b1;
                    end
                    cmd.start  = 1'b1;
                    cmd.nbytes = 2'd1;
                    cmd.byte0  = s_data_byte;
                    open_next  = 1'b1;
                    mode_next  = rtpnal_pkg::MODE_PASS;
                end
            end else if (mode_next == rtpnal_pkg::MODE_PASS) begin
                cmd.nbytes = 2'd1;
                cmd.byte0  = s_data_byte;
            end else if (mode_next == rtpnal_pkg::MODE_FRAG) begin
                if (q == fu_pos) begin
                    end_seen_next = s_data_byte[6];
                    if (s_data_byte[7]) begin
                        if (open_next) begin
                            cmd.abandon = 1'b1;
                        end
                        cmd.start = 1'b1;
                        if (hevc_next) begin
                            cmd.nbytes = 2'd2;
                            cmd.byte0  = (held_reg & rtpnal_pkg::H265_HDR_MASK)
                                       | {1'b0, s_data_byte[5:0], 1'b0};
                            cmd.byte1  = rtpnal_pkg::H265_SECOND_HDR;
                        end else begin
                            cmd.nbytes = 2'd1;
                            cmd.byte0  = (held_reg & rtpnal_pkg::H264_HDR_MASK)
                                       | {3'b000, s_data_byte[4:0]};
                        end
                        open_next = 1'b1;
                    end else if (!open_next) begin
                        mode_next = rtpnal_pkg::MODE_DROP;
                    end
                end else if (q > fu_pos) begin
                    cmd.nbytes = 2'd1;
                    cmd.byte0  = s_data_byte;
                end
            end
        end

        if (s_last_in_packet) begin
            if ((mode_next == rtpnal_pkg::MODE_PASS && open_next) ||
                (mode_next == rtpnal_pkg::MODE_FRAG && open_next && end_seen_next)) begin
                cmd.close = 1'b1;
                open_next = 1'b0;
            end
            pos_next = 9'd0;
        end else begin
            pos_next = (p == rtpnal_pkg::POS_MAX) ? rtpnal_pkg::POS_MAX : p + 9'd1;
        end

        count_next = count_reg + {31'd0, cmd.close};
        cmd.total  = count_next;
    end

    assign q_wr   = accept && (cmd.abandon || cmd.start || cmd.nbytes != 2'd0 || cmd.close);
    assign q_data = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_len_reg <= rtpnal_pkg::HEADER_LEN_RESET;
            pos_reg        <= '0;
            held_reg       <= '0;
            mode_reg       <= rtpnal_pkg::MODE_DROP;
            hevc_reg       <= 1'b0;
            end_seen_reg   <= 1'b0;
            open_reg       <= 1'b0;
            count_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                header_len_reg <= cfg_data;
            end
            if (accept) begin
                pos_reg      <= pos_next;
                held_reg     <= held_next;
                mode_reg     <= mode_next;
                hevc_reg     <= hevc_next;
                end_seen_reg <= end_seen_next;
                open_reg     <= open_next;
                count_reg    <= count_next;
            end
        end
    end

endmodule

>>> rtl/core/rtpnal_fifo.sv
// small command queue between front and back end
module rtpnal_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    wr_en,
    input  rtpnal_pkg::rtpnal_cmd_t wr_data,
    output logic                    full,
    input  logic                    rd_en,
    output rtpnal_pkg::rtpnal_cmd_t rd_data,
    output logic                    not_empty
);

    rtpnal_pkg::rtpnal_cmd_t       mem_reg [rtpnal_pkg::QDEPTH];
    logic [rtpnal_pkg::QAW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [rtpnal_pkg::QAW:0]      count_reg, count_next;
    logic                          do_wr, do_rd;

    localparam logic [rtpnal_pkg::QAW:0] DEPTH_CNT = (rtpnal_pkg::QAW + 1)'(rtpnal_pkg::QDEPTH);

    assign full      = count_reg == DEPTH_CNT;
    assign not_empty = count_reg != '0;
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/core/rtpnal_back.sv
// back end: expands each command into result beats, one per cycle while m_ready does not stall the output
module rtpnal_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_not_empty,
    input  rtpnal_pkg::rtpnal_cmd_t q_data,
    output logic                    q_rd,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              m_out_byte,
    output logic [1:0]              m_out_kind,
    output logic                    m_nal_end,
    output logic [31:0]             m_nal_total
);

    rtpnal_pkg::rtpnal_cmd_t          cur_reg, cur_next;
    logic [rtpnal_pkg::NSLOTS-1:0]    mask_reg, mask_next;
    logic                             valid_reg, valid_next;
    logic [7:0]                       byte_reg, byte_next;
    logic [1:0]                       kind_reg, kind_next;
    logic                             end_reg, end_next;
    logic [31:0]                      total_reg, total_next;
    logic                             load_out;

    function automatic logic [rtpnal_pkg::NSLOTS-1:0] cmd_mask(rtpnal_pkg::rtpnal_cmd_t c);
        logic [rtpnal_pkg::NSLOTS-1:0] m;
        m = '0;
        m[rtpnal_pkg::SLOT_ABANDON] = c.abandon;
        m[rtpnal_pkg::SLOT_SC0]     = c.start;
        m[rtpnal_pkg::SLOT_SC1]     = c.start;
        m[rtpnal_pkg::SLOT_SC2]     = c.start;
        m[rtpnal_pkg::SLOT_SC3]     = c.start;
        m[rtpnal_pkg::SLOT_BYTE0]   = c.nbytes != 2'd0;
        m[rtpnal_pkg::SLOT_BYTE1]   = c.nbytes == 2'd2;
        m[rtpnal_pkg::SLOT_END]     = c.close && c.nbytes == 2'd0;
        return m;
    endfunction

    assign load_out = !valid_reg || m_ready;

    always_comb begin
        logic [rtpnal_pkg::NSLOTS-1:0] sel_mask;
        logic [rtpnal_pkg::NSLOTS-1:0] low;
        logic [rtpnal_pkg::NSLOTS-1:0] rem;
        rtpnal_pkg::rtpnal_cmd_t       sel;
        logic                          data_end;
        q_rd = 1'b0;
        if (mask_reg != '0) begin
            sel_mask = mask_reg;
            sel      = cur_reg;
        end else begin
            sel_mask = q_not_empty ? cmd_mask(q_data) : '0;
            sel      = q_data;
            q_rd     = q_not_empty && load_out;
        end
        low      = sel_mask & (~sel_mask + 1'b1);
        rem      = sel_mask & ~low;
        data_end = sel.close && rem[rtpnal_pkg::SLOT_BYTE1:rtpnal_pkg::SLOT_SC0] == '0;

        cur_next   = cur_reg;
        mask_next  = mask_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        kind_next  = kind_reg;
        end_next   = end_reg;
        total_next = total_reg;

        if (load_out) begin
            valid_next = sel_mask != '0;
            mask_next  = rem;
            cur_next   = sel;
            total_next = sel.total;
            byte_next  = rtpnal_pkg::START_CODE_ZERO;
            kind_next  = rtpnal_pkg::KIND_DATA;
            end_next   = 1'b0;
            priority if (low[rtpnal_pkg::SLOT_ABANDON]) begin
                kind_next = rtpnal_pkg::KIND_ABANDON;
            end else if (low[rtpnal_pkg::SLOT_SC3]) begin
                byte_next = rtpnal_pkg::START_CODE_LAST;
            end else if (low[rtpnal_pkg::SLOT_BYTE0]) begin
                byte_next = sel.byte0;
                end_next  = data_end;
            end else if (low[rtpnal_pkg::SLOT_BYTE1]) begin
                byte_next = sel.byte1;
                end_next  = data_end;
            end else if (low[rtpnal_pkg::SLOT_END]) begin
                kind_next = rtpnal_pkg::KIND_END;
                end_next  = 1'b1;
            end else begin
                byte_next = rtpnal_pkg::START_CODE_ZERO;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        byte_reg  <= byte_next;
        kind_reg  <= kind_next;
        end_reg   <= end_next;
        total_reg <= total_next;
    end

    assign m_valid     = valid_reg;
    assign m_out_byte  = byte_reg;
    assign m_out_kind  = kind_reg;
    assign m_nal_end   = end_reg;
    assign m_nal_total = total_reg;

endmodule

>>> rtl/core/rtp_h264_h265_nal_depacketizer.sv
// top level: rtp h.264 / h.265 depacketizer to an annex b byte stream
// path: the first result of a byte is written to the command queue, then to the output register, before m_valid
// throughput: one input beat per cycle while the 4-entry command queue has room;
// the output register moves one result beat per cycle while m_ready does not stall it;
// one byte can yield up to 7 result beats (abandon, start code plus header)
// reset: synchronous active low; clears packet and nal state, count, queue, header_len to 12
module rtp_h264_h265_nal_depacketizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_in_packet,
    input  logic        s_last_in_packet,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_out_kind,
    output logic        m_nal_end,
    output logic [31:0] m_nal_total
);

    rtpnal_pkg::rtpnal_cmd_t wr_cmd, rd_cmd;
    logic q_wr, q_full, q_rd, q_not_empty;

    rtpnal_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_first_in_packet (s_first_in_packet),
        .s_last_in_packet  (s_last_in_packet),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .q_full            (q_full),
        .q_wr              (q_wr),
        .q_data            (wr_cmd)
    );

    rtpnal_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (q_wr),
        .wr_data   (wr_cmd),
        .full      (q_full),
        .rd_en     (q_rd),
        .rd_data   (rd_cmd),
        .not_empty (q_not_empty)
    );

    rtpnal_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (rd_cmd),
        .q_rd        (q_rd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_kind  (m_out_kind),
        .m_nal_end   (m_nal_end),
        .m_nal_total (m_nal_total)
    );

    a_end_kind_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind == rtpnal_pkg::KIND_END |-> m_nal_end && m_out_byte == 8'd0)
        else $error("end beat without nal_end");

    a_abandon_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind == rtpnal_pkg::KIND_ABANDON |-> !m_nal_end && m_out_byte == 8'd0)
        else $error("abandon beat carries data or end");

    a_no_write_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_wr)
        else $error("queue written while full");

    a_pop_only_with_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_rd |-> q_not_empty)
        else $error("queue read while empty");

endmodule

>>> sim/rtp_h264_h265_nal_depacketizer_tb.sv
`timescale 1ns / 1ps
// testbench for the rtp h.264 / h.265 nal depacketizer: directed packets, random streams
module rtp_h264_h265_nal_depacketizer_tb;

    typedef struct packed {
        logic [7:0]  data;
        logic [1:0]  kind;
        logic        fin;
        logic [31:0] total;
    } nal_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_first_in_packet = 1'b0;
    logic        s_last_in_packet = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic [1:0]  m_out_kind;
    logic        m_nal_end;
    logic [31:0] m_nal_total;

    // predictor state
    logic [7:0]  hdr_len_m;
    logic [8:0]  pos_m;
    logic [7:0]  fu_ind_m;
    logic [1:0]  mode_m;
    logic        hevc_m;
    logic        fu_end_m;
    logic        open_m;
    logic [31:0] nal_cnt_m;

    nal_beat_t   step_beats[$];
    nal_beat_t   pending_stream[$];
    logic [7:0]  pkt_q[$];

    int mismatches = 0;
    int out_beats = 0;
    int payload_sent = 0;
    int burst_left = 0;
    int gap_max = 0;
    int ready_stall_pct = 0;

    rtp_h264_h265_nal_depacketizer dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_first_in_packet (s_first_in_packet),
        .s_last_in_packet  (s_last_in_packet),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_out_kind        (m_out_kind),
        .m_nal_end         (m_nal_end),
        .m_nal_total       (m_nal_total)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= (ready_stall_pct == 0) || ($urandom_range(0, 99) >= ready_stall_pct);
    end

    function automatic void emit(input logic [1:0] kind, input logic [7:0] data,
                                 input logic fin);
        nal_beat_t r;
        r.data = data;
        r.kind = kind;
        r.fin = fin;
        r.total = '0;
        step_beats.push_back(r);
    endfunction

    function automatic void abandon_open();
        if (open_m) begin
            emit(rtpnal_pkg::KIND_ABANDON, 8'h00, 1'b0);
            open_m = 1'b0;
        end
    endfunction

    function automatic void emit_start_code();
        emit(rtpnal_pkg::KIND_DATA, rtpnal_pkg::START_CODE_ZERO, 1'b0);
        emit(rtpnal_pkg::KIND_DATA, rtpnal_pkg::START_CODE_ZERO, 1'b0);
        emit(rtpnal_pkg::KIND_DATA, rtpnal_pkg::START_CODE_ZERO, 1'b0);
        emit(rtpnal_pkg::KIND_DATA, rtpnal_pkg::START_CODE_LAST, 1'b0);
    endfunction

    function automatic void depacketize_byte(input logic [7:0] b, input logic first,
                                             input logic last);
        logic [8:0] p;
        logic [8:0] q;
        logic [8:0] fu_pos;
        nal_beat_t  r;
        step_beats.delete();
        p = first ? 9'd0 : pos_m;
        if (p == 9'd0) begin
            if (mode_m == rtpnal_pkg::MODE_PASS) abandon_open();
            mode_m = rtpnal_pkg::MODE_DROP;
            hevc_m = 1'b0;
            fu_end_m = 1'b0;
        end
        if (p >= {1'b0, hdr_len_m}) begin
            q = p - {1'b0, hdr_len_m};
            fu_pos = hevc_m ? rtpnal_pkg::H265_FU_POS : rtpnal_pkg::H264_FU_POS;
            if (q == 9'd0) begin
                if (b[4:0] == rtpnal_pkg::H264_FU_TYPE) begin
                    mode_m = rtpnal_pkg::MODE_FRAG;
                    hevc_m = 1'b0;
                    fu_ind_m = b;
                end else if (b[6:1] == rtpnal_pkg::H265_FU_TYPE) begin
                    mode_m = rtpnal_pkg::MODE_FRAG;
                    hevc_m = 1'b1;
                    fu_ind_m = b;
                end else begin
                    abandon_open();
                    emit_start_code();
                    emit(rtpnal_pkg::KIND_DATA, b, 1'b0);
                    open_m = 1'b1;
                    mode_m = rtpnal_pkg::MODE_PASS;
                end
            end else if (mode_m == rtpnal_pkg::MODE_PASS) begin
                emit(rtpnal_pkg::KIND_DATA, b, 1'b0);
            end else if (mode_m == rtpnal_pkg::MODE_FRAG) begin
                if (q == fu_pos) begin
                    fu_end_m = b[6];
                    if (b[7]) begin
                        abandon_open();
                        emit_start_code();
                        if (hevc_m) begin
                            emit(rtpnal_pkg::KIND_DATA,
                                 (fu_ind_m & rtpnal_pkg::H265_HDR_MASK)
                                 | {1'b0, b[5:0], 1'b0},
                                 1'b0);
                            emit(rtpnal_pkg::KIND_DATA, rtpnal_pkg::H265_SECOND_HDR, 1'b0);
                        end else begin
                            emit(rtpnal_pkg::KIND_DATA,
                                 (fu_ind_m & rtpnal_pkg::H264_HDR_MASK)
                                 | {3'b000, b[4:0]},
                                 1'b0);
                        end
                        open_m = 1'b1;
                    end else if (!open_m) begin
                        mode_m = rtpnal_pkg::MODE_DROP;
                    end
                end else if (q > fu_pos) begin
                    emit(rtpnal_pkg::KIND_DATA, b, 1'b0);
                end
            end
        end
        if (last) begin
            if (open_m && (mode_m == rtpnal_pkg::MODE_PASS ||
                           (mode_m == rtpnal_pkg::MODE_FRAG && fu_end_m))) begin
                if (step_beats.size() > 0 &&
                    step_beats[step_beats.size() - 1].kind == rtpnal_pkg::KIND_DATA) begin
                    r = step_beats.pop_back();
                    r.fin = 1'b1;
                    step_beats.push_back(r);
                end else begin
                    emit(rtpnal_pkg::KIND_END, 8'h00, 1'b1);
                end
                open_m = 1'b0;
                nal_cnt_m = nal_cnt_m + 32'd1;
            end
            pos_m = 9'd0;
        end else begin
            pos_m = (p >= rtpnal_pkg::POS_MAX) ? rtpnal_pkg::POS_MAX : p + 9'd1;
        end
        foreach (step_beats[i]) begin
            r = step_beats[i];
            r.total = nal_cnt_m;
            pending_stream.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at result beat %0d: got %0h expected %0h",
                 what, out_beats, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        nal_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_stream.size() == 0) begin
                report_mismatch("unexpected beat", {24'h0, m_out_byte}, 32'h0);
            end else begin
                want = pending_stream.pop_front();
                if (m_out_byte !== want.data)
                    report_mismatch("out_byte", {24'h0, m_out_byte}, {24'h0, want.data});
                if (m_out_kind !== want.kind)
                    report_mismatch("out_kind", {30'h0, m_out_kind}, {30'h0, want.kind});
                if (m_nal_end !== want.fin)
                    report_mismatch("nal_end", {31'h0, m_nal_end}, {31'h0, want.fin});
                if (m_nal_total !== want.total)
                    report_mismatch("nal_total", m_nal_total, want.total);
            end
            out_beats++;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_first_in_packet <= f;
        s_last_in_packet <= l;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        depacketize_byte(b, f, l);
    endtask

    task automatic send_packet(input int hdr_n, input bit mark_first, input bit mark_last);
        int n;
        int i;
        logic [7:0] b;
        n = hdr_n + pkt_q.size();
        for (i = 0; i < n; i++) begin
            if (i < hdr_n) begin
                b = 8'($urandom);
            end else begin
                b = pkt_q[i - hdr_n];
                payload_sent++;
            end
            send_byte(b, mark_first && i == 0, mark_last && i == n - 1);
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_stream.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_header_len(input logic [7:0] v);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        hdr_len_m = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void fill_single(input int len);
        logic [7:0] b;
        int i;
        pkt_q.delete();
        do begin
            b = 8'($urandom);
        end while (b[4:0] == rtpnal_pkg::H264_FU_TYPE || b[6:1] == rtpnal_pkg::H265_FU_TYPE);
        pkt_q.push_back(b);
        for (i = 1; i < len; i++) pkt_q.push_back(8'($urandom));
    endfunction

    function automatic void fill_fu(input bit hevc, input bit s, input bit e, input int len);
        logic [7:0]  r;
        logic [31:0] r2;
        int i;
        r = 8'($urandom);
        r2 = $urandom;
        pkt_q.delete();
        if (hevc) begin
            pkt_q.push_back({r[7], rtpnal_pkg::H265_FU_TYPE, r[0]});
            pkt_q.push_back(r2[15:8]);
        end else begin
            pkt_q.push_back({r[7:5], rtpnal_pkg::H264_FU_TYPE});
        end
        pkt_q.push_back({s, e, r2[5:0]});
        for (i = 0; i < len; i++) pkt_q.push_back(8'($urandom));
    endfunction

    task automatic check_default_header();
        pkt_q = '{8'h00, 8'hFF};
        send_packet(hdr_len_m, 1'b1, 1'b1);
    endtask

    task automatic check_single_nal();
        write_header_len(8'd0);
        pkt_q = '{8'hFF};
        send_packet(0, 1'b1, 1'b1);
    endtask

    task automatic check_fu_a();
        pkt_q = '{8'h7C, 8'h85, 8'h11};
        send_packet(0, 1'b1, 1'b1);
        pkt_q = '{8'h7C, 8'h05, 8'h22};
        send_packet(0, 1'b1, 1'b1);
        // end fragment with no data after the fu header
        pkt_q = '{8'h7C, 8'h45};
        send_packet(0, 1'b1, 1'b1);
    endtask

    task automatic check_h265_fu();
        pkt_q = '{8'h62, 8'h01, 8'h93, 8'hAB};
        send_packet(0, 1'b1, 1'b1);
        pkt_q = '{8'h63, 8'h01, 8'h53, 8'hCD};
        send_packet(0, 1'b1, 1'b1);
        // start and end in one fragment
        pkt_q = '{8'hE3, 8'hFF, 8'hFF};
        send_packet(0, 1'b1, 1'b1);
    endtask

    task automatic check_abandon();
        pkt_q = '{8'h5C, 8'h81, 8'h01};
        send_packet(0, 1'b1, 1'b1);
        pkt_q = '{8'h41, 8'h02};
        send_packet(0, 1'b1, 1'b1);
        pkt_q = '{8'h5C, 8'h81};
        send_packet(0, 1'b1, 1'b1);
        pkt_q = '{8'h5C, 8'hC2, 8'h03};
        send_packet(0, 1'b1, 1'b1);
    endtask

    task automatic check_cut_single();
        pkt_q = '{8'h41, 8'h05};
        send_packet(0, 1'b1, 1'b0);
        pkt_q = '{8'h67};
        send_packet(0, 1'b1, 1'b1);
    endtask

    task automatic check_orphan_continuation();
        pkt_q = '{8'h5C, 8'h05, 8'h44, 8'h55};
        send_packet(0, 1'b1, 1'b1);
    endtask

    task automatic check_short_packets();
        write_header_len(8'd3);
        pkt_q = '{8'h7C, 8'h81, 8'h10};
        send_packet(3, 1'b1, 1'b1);
        pkt_q.delete();
        send_packet(2, 1'b1, 1'b1);
        pkt_q = '{8'h7C};
        send_packet(3, 1'b1, 1'b1);
        pkt_q = '{8'h62, 8'h01};
        send_packet(3, 1'b1, 1'b1);
        pkt_q = '{8'h7C, 8'h41, 8'h20};
        send_packet(3, 1'b1, 1'b1);
    endtask

    task automatic check_header_extremes();
        // packet that ends inside the longest header
        write_header_len(8'd255);
        pkt_q.delete();
        send_packet(4, 1'b1, 1'b1);
        write_header_len(8'd0);
        // packet boundary marked only by the previous last byte
        pkt_q = '{8'h09, 8'h10};
        send_packet(0, 1'b0, 1'b1);
    endtask

    task automatic check_random_stream();
        int phase;
        int pick;
        int nfrag;
        int f;
        int target;
        bit hevc;
        bit mark_last;
        bit paused;
        paused = 1'b0;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_header_len(8'd0);
                    gap_max = 0;
                    ready_stall_pct = 0;
                end
                1: begin
                    write_header_len(8'd1);
                    gap_max = 3;
                    ready_stall_pct = 30;
                end
                2: begin
                    write_header_len(8'd2);
                    gap_max = 8;
                    ready_stall_pct = 60;
                end
                default: begin
                    write_header_len(8'($urandom_range(3, 6)));
                    gap_max = 2;
                    ready_stall_pct = 15;
                end
            endcase
            target = payload_sent + 40;
            while (payload_sent < target) begin
                pick = $urandom_range(0, 99);
                hevc = 1'($urandom_range(0, 1));
                if (pick < 60) begin
                    nfrag = $urandom_range(1, 4);
                    for (f = 0; f < nfrag; f++) begin
                        fill_fu(hevc, f == 0, f == nfrag - 1, $urandom_range(0, 6));
                        send_packet(hdr_len_m, $urandom_range(0, 3) != 0, 1'b1);
                    end
                end else if (pick < 80) begin
                    fill_single($urandom_range(1, 8));
                    send_packet(hdr_len_m, 1'b1, 1'b1);
                end else if (pick < 90) begin
                    mark_last = 1'b1;
                    case ($urandom_range(0, 2))
                        0: fill_fu(hevc, 1'b0, 1'($urandom_range(0, 1)),
                                   $urandom_range(0, 4));
                        1: fill_fu(hevc, 1'b1, 1'b0, $urandom_range(0, 4));
                        default: begin
                            fill_single($urandom_range(1, 4));
                            mark_last = 1'b0;
                        end
                    endcase
                    send_packet(hdr_len_m, 1'b1, mark_last);
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        send_byte(8'($urandom), $urandom_range(0, 7) == 0,
                                  $urandom_range(0, 7) == 0);
                        payload_sent++;
                    end
                end
                if (phase == 1 && !paused && payload_sent >= target - 20) begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial begin
        hdr_len_m = rtpnal_pkg::HEADER_LEN_RESET;
        pos_m = '0;
        fu_ind_m = '0;
        mode_m = rtpnal_pkg::MODE_DROP;
        hevc_m = 1'b0;
        fu_end_m = 1'b0;
        open_m = 1'b0;
        nal_cnt_m = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        check_default_header();
        check_single_nal();
        check_fu_a();
        check_h265_fu();
        check_abandon();
        check_cut_single();
        check_orphan_continuation();
        check_short_packets();
        check_header_extremes();
        check_random_stream();

        wait_idle();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
